[design/teg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables for the text escape glyph renderer.
// No dependencies.
package teg_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  column_x;
        logic [7:0]  column_y;
        logic [1:0]  dot_scale;
        logic [7:0]  column_bits;
        logic [15:0] on_color;
        logic [15:0] off_color;
        logic        last_column;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SLASH, PH_DOLLAR, PH_DOLLAR_DIGIT, PH_HEX
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE, ACT_GLYPH, ACT_NEWLINE, ACT_TAB
    } t_act_kind;

    typedef struct packed {
        t_act_kind  kind;
        logic [6:0] idx;
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE, S_FETCH, S_EMIT
    } t_state;

    // Outcome of decoding one byte against the escape state.
    typedef struct packed {
        logic [7:0]        row;
        logic [7:0]        col;
        logic [23:0]       color;
        logic              scale_big;
        t_phase            phase;
        logic [7:0]        pend0;
        logic [7:0]        pend1;
        logic [23:0]       hex;
        t_action [3:0]     acts;
        logic [2:0]        act_cnt;
    } t_dec;

    localparam int unsigned MAX_ACTS = 4;
    localparam int unsigned COLS_PER_GLYPH = 5;
    localparam logic [1:0]  MAX_GLYPHS_OUT = 2'd3;

    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [7:0]  QMARK_IDX = 8'd31;
    localparam logic [7:0]  SLASH_CH = 8'h2F;
    localparam logic [7:0]  DOLLAR_CH = 8'h24;

    function automatic logic [15:0] to565(input logic [23:0] c);
        to565 = {c[23:19], c[15:10], c[7:3]};
    endfunction

    // Named colors: {hit, rgb}
    function automatic logic [24:0] named_color(input logic [7:0] b);
        case (b)
            "r":      named_color = {1'b1, 24'hFF0000};
            "g":      named_color = {1'b1, 24'h00FF00};
            "b":      named_color = {1'b1, 24'h0000FF};
            "y":      named_color = {1'b1, 24'hFFFF00};
            "c":      named_color = {1'b1, 24'h00FFFF};
            "m":      named_color = {1'b1, 24'hFF00FF};
            "w", "k": named_color = {1'b1, COLOR_WHITE};
            "R":      named_color = {1'b1, 24'hFF7777};
            "G":      named_color = {1'b1, 24'h77FF77};
            "B":      named_color = {1'b1, 24'h7777FF};
            "o":      named_color = {1'b1, 24'hFF7700};
            "l":      named_color = {1'b1, 24'h77FF00};
            "t":      named_color = {1'b1, 24'h00FF77};
            "e":      named_color = {1'b1, 24'h0077FF};
            "p":      named_color = {1'b1, 24'h7700FF};
            "M":      named_color = {1'b1, 24'hFF0077};
            "A":      named_color = {1'b1, 24'h888888};
            "a":      named_color = {1'b1, 24'h444444};
            default:  named_color = 25'd0;
        endcase
    endfunction

    // Five columns per glyph, column 0 in the top byte.
    function automatic logic [39:0] glyph_cols(input logic [6:0] idx);
        case (idx)
            7'd0:  glyph_cols = 40'h0000000000;
            7'd1:  glyph_cols = 40'h0000FA0000;
            7'd2:  glyph_cols = 40'h00C000C000;
            7'd3:  glyph_cols = 40'h287C287C28;
            7'd4:  glyph_cols = 40'h6492FE924C;
            7'd5:  glyph_cols = 40'h4408102044;
            7'd6:  glyph_cols = 40'h0CF2AACA04;
            7'd7:  glyph_cols = 40'h0000C00000;
            7'd8:  glyph_cols = 40'h00007C8200;
            7'd9:  glyph_cols = 40'h00827C0000;
            7'd10: glyph_cols = 40'h54387C3854;
            7'd11: glyph_cols = 40'h10107C1010;
            7'd12: glyph_cols = 40'h0001020000;
            7'd13: glyph_cols = 40'h1010101010;
            7'd14: glyph_cols = 40'h0000020000;
            7'd15: glyph_cols = 40'h0408102040;
            7'd16: glyph_cols = 40'h7C8282827C;
            7'd17: glyph_cols = 40'h0042FE0200;
            7'd18: glyph_cols = 40'h42868A9262;
            7'd19: glyph_cols = 40'h448292926C;
            7'd20: glyph_cols = 40'h182848FE08;
            7'd21: glyph_cols = 40'hE4A2A2A29C;
            7'd22: glyph_cols = 40'h7C9292924C;
            7'd23: glyph_cols = 40'h80808E90E0;
            7'd24: glyph_cols = 40'h6C9292926C;
            7'd25: glyph_cols = 40'h649292927C;
            7'd26: glyph_cols = 40'h0000440000;
            7'd27: glyph_cols = 40'h0000460000;
            7'd28: glyph_cols = 40'h0000102844;
            7'd29: glyph_cols = 40'h2828282828;
            7'd30: glyph_cols = 40'h4428100000;
            7'd31: glyph_cols = 40'h40808A9060;
            7'd32: glyph_cols = 40'h7C82BAAA7A;
            7'd33: glyph_cols = 40'h7E9090907E;
            7'd34: glyph_cols = 40'hFE9292926C;
            7'd35: glyph_cols = 40'h7C82828244;
            7'd36: glyph_cols = 40'hFE82824438;
            7'd37: glyph_cols = 40'hFE92929282;
            7'd38: glyph_cols = 40'hFE90909080;
            7'd39: glyph_cols = 40'h7C8282925C;
            7'd40: glyph_cols = 40'hFE101010FE;
            7'd41: glyph_cols = 40'h0082FE8200;
            7'd42: glyph_cols = 40'h0082FC8000;
            7'd43: glyph_cols = 40'hFE10284482;
            7'd44: glyph_cols = 40'hFE02020202;
            7'd45: glyph_cols = 40'hFE402040FE;
            7'd46: glyph_cols = 40'hFE201008FE;
            7'd47: glyph_cols = 40'h7C8282827C;
            7'd48: glyph_cols = 40'hFE90909060;
            7'd49: glyph_cols = 40'h788484867C;
            7'd50: glyph_cols = 40'hFE90989462;
            7'd51: glyph_cols = 40'h649292924C;
            7'd52: glyph_cols = 40'h8080FE8080;
            7'd53: glyph_cols = 40'hFC020202FC;
            7'd54: glyph_cols = 40'hF00C020CF0;
            7'd55: glyph_cols = 40'hFE040804FE;
            7'd56: glyph_cols = 40'hC6281028C6;
            7'd57: glyph_cols = 40'hC0201E20C0;
            7'd58: glyph_cols = 40'h868A92A2C2;
            7'd59: glyph_cols = 40'h0000FE8200;
            7'd60: glyph_cols = 40'h4020100804;
            7'd61: glyph_cols = 40'h0082FE0000;
            7'd62: glyph_cols = 40'h2040804020;
            7'd63: glyph_cols = 40'h0101010101;
            7'd64: glyph_cols = 40'h0000C04000;
            7'd65: glyph_cols = 40'h042A2A2A1E;
            7'd66: glyph_cols = 40'hFE1212120C;
            7'd67: glyph_cols = 40'h1C22222214;
            7'd68: glyph_cols = 40'h0C121212FE;
            7'd69: glyph_cols = 40'h1C2A2A2A18;
            7'd70: glyph_cols = 40'h00107E9000;
            7'd71: glyph_cols = 40'h081515151E;
            7'd72: glyph_cols = 40'hFE1010100E;
            7'd73: glyph_cols = 40'h0022BE0200;
            7'd74: glyph_cols = 40'h0021BE0000;
            7'd75: glyph_cols = 40'hFE08140200;
            7'd76: glyph_cols = 40'h0082FE0200;
            7'd77: glyph_cols = 40'h1E100C100E;
            7'd78: glyph_cols = 40'h1E1010100E;
            7'd79: glyph_cols = 40'h1C2222221C;
            7'd80: glyph_cols = 40'h1F14141408;
            7'd81: glyph_cols = 40'h081414141F;
            7'd82: glyph_cols = 40'h3E08102020;
            7'd83: glyph_cols = 40'h122A2A2A24;
            7'd84: glyph_cols = 40'h00107E1200;
            7'd85: glyph_cols = 40'h1C0202021C;
            7'd86: glyph_cols = 40'h1804020418;
            7'd87: glyph_cols = 40'h1C021C021C;
            7'd88: glyph_cols = 40'h2214081422;
            7'd89: glyph_cols = 40'h1109060418;
            7'd90: glyph_cols = 40'h22262A3222;
            7'd91: glyph_cols = 40'h00106C8200;
            7'd92: glyph_cols = 40'h0000FE0000;
            7'd93: glyph_cols = 40'h00826C1000;
            7'd94: glyph_cols = 40'h1820100830;
            7'd95: glyph_cols = 40'h0E1222120E;
            7'd96: glyph_cols = 40'h7C7C7C7C7C;
            7'd97: glyph_cols = 40'h7C4444447C;
            7'd98: glyph_cols = 40'h387C7C7C38;
            default: glyph_cols = 40'h0000000000;
        endcase
    endfunction

endpackage

[design/teg_glyph_rom.sv]
`timescale 1ns / 1ps
// Glyph pattern ROM, one 40-bit word (five columns) per glyph, registered read.
// Depends on teg_pkg.
module teg_glyph_rom
    import teg_pkg::*;
(
    input  logic        i_clk,
    input  logic [6:0]  i_addr,
    output logic [39:0] o_cols
);

    logic [39:0] r_cols;

    always_ff @(posedge i_clk) begin
        r_cols <= glyph_cols(i_addr);
    end

    assign o_cols = r_cols;

endmodule

[design/teg_decode.sv]
`timescale 1ns / 1ps
// Escape parser: one byte against the current escape state gives the new
// cursor/color state and a short list of glyph/newline/tab actions. Uses teg_pkg.
module teg_decode
    import teg_pkg::*;
#(
    parameter int unsigned GLYPH_COUNT    = 99,
    parameter int unsigned MAX_ROW_ESCAPE = 6
) (
    input  t_in_item    i_item,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  logic [23:0] i_color,
    input  logic        i_scale_big,
    input  t_phase      i_phase,
    input  logic [7:0]  i_pend0,
    input  logic [7:0]  i_pend1,
    input  logic [23:0] i_hex,
    output t_dec        o_dec
);

    localparam logic [7:0] ROW_DIGIT_MAX = 8'(48 + MAX_ROW_ESCAPE);
    localparam logic [7:0] GLYPH_LIMIT   = 8'(GLYPH_COUNT);

    function automatic logic [6:0] clamp_idx(input logic [7:0] idx);
        clamp_idx = (idx >= GLYPH_LIMIT || idx >= 8'd128) ? QMARK_IDX[6:0] : idx[6:0];
    endfunction

    function automatic logic [6:0] char_idx(input logic [7:0] b);
        logic [7:0] bb;
        bb = (b < 8'd32 || b >= 8'd128) ? 8'd63 : b;
        char_idx = clamp_idx(bb - 8'd32);
    endfunction

    function automatic t_action glyph_act(input logic [6:0] idx);
        glyph_act.kind = ACT_GLYPH;
        glyph_act.idx  = idx;
    endfunction

    function automatic t_action plain_act(input logic [7:0] b);
        plain_act.idx = char_idx(b);
        case (b)
            8'h0D:   plain_act.kind = ACT_NONE;
            8'h0A:   plain_act.kind = ACT_NEWLINE;
            8'h09:   plain_act.kind = ACT_TAB;
            default: plain_act.kind = ACT_GLYPH;
        endcase
    endfunction

    // Row escape with clamping; d is at most 15.
    function automatic logic [7:0] row_of(input logic [3:0] d, input logic big);
        logic [7:0] r;
        r = big ? 8'(1 + 18 * d) : 8'(1 + 9 * d);
        if (r > 8'd60 || (r >= 8'd54 && big))
            r = big ? 8'd36 : 8'd18;
        row_of = r;
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [7:0] v;
        if (b >= "0" && b <= "9") v = b - "0";
        else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
        else v = b - "a" + 8'd10;
        hex_digit = v[3:0];
    endfunction

    t_dec       d;
    t_action    a;
    logic [7:0] b;
    logic [3:0] v;
    logic [24:0] nc;
    logic       is_hex;

    always_comb begin
        d         = '0;
        d.row     = i_row;
        d.col     = i_col;
        d.color   = i_color;
        d.scale_big = i_scale_big;
        d.phase   = i_phase;
        d.pend0   = i_pend0;
        d.pend1   = i_pend1;
        d.hex     = i_hex;
        b         = i_item.text_byte;
        a         = '0;
        v         = '0;
        nc        = named_color(b);
        is_hex    = (b >= "0" && b <= "9") || (b >= "A" && b <= "F")
                 || (b >= "a" && b <= "f");

        // escape phase plus the leftover plain byte handling
        case (i_phase)
            PH_SLASH: begin
                d.phase = PH_IDLE;
                if (b >= "0" && b <= ROW_DIGIT_MAX) begin
                    d.row = row_of(4'(b - "0"), i_scale_big);
                    d.col = 8'd1;
                end else if (b == "#") begin
                    d.phase = PH_HEX;
                    d.pend1 = 8'd0;
                    d.hex   = 24'd0;
                end else if (b == "S") begin
                    d.scale_big = 1'b1;
                end else if (b == "s") begin
                    d.scale_big = 1'b0;
                end else if (nc[24]) begin
                    d.color = nc[23:0];
                end else if (b == SLASH_CH) begin
                    d.acts[0] = glyph_act(char_idx(SLASH_CH));
                    d.act_cnt = 3'd1;
                end else if (b == "*") begin
                    d.acts[0] = glyph_act(clamp_idx(8'd98));
                    d.act_cnt = 3'd1;
                end else if (b == "q") begin
                    d.acts[0] = glyph_act(clamp_idx(8'd97));
                    d.act_cnt = 3'd1;
                end else if (b == "Q") begin
                    d.acts[0] = glyph_act(clamp_idx(8'd96));
                    d.act_cnt = 3'd1;
                end else begin
                    d.acts[0] = glyph_act(char_idx(SLASH_CH));
                    d.act_cnt = 3'd1;
                    if (b == SLASH_CH) d.phase = PH_SLASH;
                    else if (b == DOLLAR_CH) d.phase = PH_DOLLAR;
                    else begin
                        a = plain_act(b);
                        if (a.kind != ACT_NONE) begin
                            d.acts[1] = a;
                            d.act_cnt = 3'd2;
                        end
                    end
                end
            end
            PH_DOLLAR: begin
                if (b >= "0" && b <= ROW_DIGIT_MAX) begin
                    d.pend0 = b;
                    d.phase = PH_DOLLAR_DIGIT;
                end else begin
                    d.phase   = PH_IDLE;
                    d.acts[0] = glyph_act(char_idx(DOLLAR_CH));
                    d.act_cnt = 3'd1;
                    if (b == SLASH_CH) d.phase = PH_SLASH;
                    else if (b == DOLLAR_CH) d.phase = PH_DOLLAR;
                    else begin
                        a = plain_act(b);
                        if (a.kind != ACT_NONE) begin
                            d.acts[1] = a;
                            d.act_cnt = 3'd2;
                        end
                    end
                end
            end
            PH_DOLLAR_DIGIT: begin
                d.phase = PH_IDLE;
                if ((b >= "0" && b <= "9") || (b >= "A" && b <= "F")) begin
                    v     = hex_digit(b);
                    d.row = row_of(4'(i_pend0 - "0"), i_scale_big);
                    d.col = i_scale_big ? 8'(1 + 12 * v) : 8'(1 + 6 * v);
                end else begin
                    d.acts[0] = glyph_act(char_idx(DOLLAR_CH));
                    d.acts[1] = glyph_act(char_idx(i_pend0));
                    d.act_cnt = 3'd2;
                    if (b == SLASH_CH) d.phase = PH_SLASH;
                    else if (b == DOLLAR_CH) d.phase = PH_DOLLAR;
                    else begin
                        a = plain_act(b);
                        if (a.kind != ACT_NONE) begin
                            d.acts[2] = a;
                            d.act_cnt = 3'd3;
                        end
                    end
                end
            end
            PH_HEX: begin
                if (is_hex) d.hex = {i_hex[19:0], hex_digit(b)};
                d.pend1 = i_pend1 + 8'd1;
                if (d.pend1 >= 8'd6) begin
                    d.color = d.hex;
                    d.phase = PH_IDLE;
                end
            end
            default: begin
                d.phase = PH_IDLE;
                if (b == SLASH_CH) d.phase = PH_SLASH;
                else if (b == DOLLAR_CH) d.phase = PH_DOLLAR;
                else begin
                    a = plain_act(b);
                    if (a.kind != ACT_NONE) begin
                        d.acts[0] = a;
                        d.act_cnt = 3'd1;
                    end
                end
            end
        endcase

        // end of text resolves whatever escape is still open
        if (i_item.end_of_text) begin
            case (d.phase)
                PH_SLASH: begin
                    d.acts[d.act_cnt[1:0]] = glyph_act(char_idx(SLASH_CH));
                    d.act_cnt = d.act_cnt + 3'd1;
                end
                PH_DOLLAR: begin
                    d.acts[d.act_cnt[1:0]] = glyph_act(char_idx(DOLLAR_CH));
                    d.act_cnt = d.act_cnt + 3'd1;
                end
                PH_DOLLAR_DIGIT: begin
                    // only reachable with no prior actions
                    d.acts[0] = glyph_act(char_idx(DOLLAR_CH));
                    d.acts[1] = glyph_act(char_idx(d.pend0));
                    d.act_cnt = 3'd2;
                end
                PH_HEX: d.color = d.hex;
                default: ;
            endcase
            d.phase = PH_IDLE;
        end
        o_dec = d;
    end

endmodule

[design/text_escape_glyph_renderer_core.sv]
`timescale 1ns / 1ps
// Top level: cursor/color state, action sequencer and output register.
// Depends on teg_pkg, teg_decode, teg_glyph_rom.
//
//   channel | direction | handshake               | payload
//   input   | in        | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//   output  | out       | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//   config  | in        | i_cfg_we                | i_cfg_data (24-bit background)
//
// A byte is decoded in its accept cycle. Each glyph then takes an S_FETCH state for
// the ROM read plus five column transfers in S_EMIT, newline/tab are handled in
// S_FETCH, and a final S_FETCH returns to idle; o_in_stall is held from the accept
// until that return. A byte with no actions never leaves S_IDLE.
// Up to three actions per byte. Output stalls hold the column sequencer.
// Reset is synchronous and returns cursor, color, scale and escape state to their defaults.
module text_escape_glyph_renderer_core
    import teg_pkg::*;
#(
    parameter int unsigned GLYPH_COUNT    = 99,
    parameter int unsigned MAX_ROW_ESCAPE = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data
);

    t_state      r_state, n_state;
    logic [7:0]  r_row, n_row;
    logic [7:0]  r_col, n_col;
    logic [23:0] r_color, n_color;
    logic        r_scale_big, n_scale_big;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_pend0, n_pend0;
    logic [7:0]  r_pend1, n_pend1;
    logic [23:0] r_hex, n_hex;
    logic [23:0] r_bg;
    t_action [3:0] r_acts, n_acts;
    logic [2:0]  r_act_cnt, n_act_cnt;
    logic [2:0]  r_ptr, n_ptr;
    logic [1:0]  r_gnum, n_gnum;
    logic [2:0]  r_cidx, n_cidx;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_dec        dec;
    logic [39:0] rom_cols;
    logic        in_xfer, out_free, later_glyph;
    t_action     cur;
    logic [7:0]  step6, step9;

    teg_decode #(
        .GLYPH_COUNT    (GLYPH_COUNT),
        .MAX_ROW_ESCAPE (MAX_ROW_ESCAPE)
    ) u_decode (
        .i_item      (i_in_data),
        .i_row       (r_row),
        .i_col       (r_col),
        .i_color     (r_color),
        .i_scale_big (r_scale_big),
        .i_phase     (r_phase),
        .i_pend0     (r_pend0),
        .i_pend1     (r_pend1),
        .i_hex       (r_hex),
        .o_dec       (dec)
    );

    assign cur = r_acts[r_ptr[1:0]];

    teg_glyph_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (cur.idx),
        .o_cols (rom_cols)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step6      = r_scale_big ? 8'd12 : 8'd6;
    assign step9      = r_scale_big ? 8'd18 : 8'd9;

    always_comb begin
        later_glyph = 1'b0;
        for (int i = 0; i < MAX_ACTS; i++) begin
            if (3'(i) > r_ptr && 3'(i) < r_act_cnt && r_acts[i].kind == ACT_GLYPH)
                later_glyph = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer && dec.act_cnt != 3'd0) n_state = S_FETCH;
            S_FETCH: begin
                if (r_ptr == r_act_cnt) n_state = S_IDLE;
                else if (cur.kind == ACT_GLYPH && r_gnum != MAX_GLYPHS_OUT)
                    n_state = S_EMIT;
            end
            S_EMIT:  if (out_free && r_cidx == 3'(COLS_PER_GLYPH - 1)) n_state = S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_row       = r_row;
        n_col       = r_col;
        n_color     = r_color;
        n_scale_big = r_scale_big;
        n_phase     = r_phase;
        n_pend0     = r_pend0;
        n_pend1     = r_pend1;
        n_hex       = r_hex;
        n_acts      = r_acts;
        n_act_cnt   = r_act_cnt;
        n_ptr       = r_ptr;
        n_gnum      = r_gnum;
        n_cidx      = r_cidx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_row       = dec.row;
                    n_col       = dec.col;
                    n_color     = dec.color;
                    n_scale_big = dec.scale_big;
                    n_phase     = dec.phase;
                    n_pend0     = dec.pend0;
                    n_pend1     = dec.pend1;
                    n_hex       = dec.hex;
                    n_acts      = dec.acts;
                    n_act_cnt   = dec.act_cnt;
                    n_ptr       = 3'd0;
                    n_gnum      = 2'd0;
                    n_cidx      = 3'd0;
                end
            end
            S_FETCH: begin
                if (r_ptr != r_act_cnt) begin
                    case (cur.kind)
                        ACT_NEWLINE: begin
                            n_row = r_row + step9;
                            n_col = 8'd1;
                            n_ptr = r_ptr + 3'd1;
                        end
                        ACT_TAB: begin
                            if (r_col < 8'd25 && !r_scale_big) n_col = 8'd25;
                            else if (r_col < 8'd49) n_col = 8'd49;
                            else if (r_col < 8'd73 && !r_scale_big) n_col = 8'd75;
                            else begin
                                n_col = 8'd1;
                                n_row = r_row + step9;
                            end
                            n_ptr = r_ptr + 3'd1;
                        end
                        ACT_GLYPH: begin
                            // glyphs past the result limit only move the cursor
                            if (r_gnum == MAX_GLYPHS_OUT) begin
                                n_col = r_col + step6;
                                n_ptr = r_ptr + 3'd1;
                            end
                        end
                        default: n_ptr = r_ptr + 3'd1;
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.column_x       = r_col + (r_scale_big ? {4'd0, r_cidx, 1'b0}
                                                                : {5'd0, r_cidx});
                    n_out.column_y       = r_row;
                    n_out.dot_scale      = r_scale_big ? 2'd2 : 2'd1;
                    n_out.column_bits    = rom_cols[8'd39 - {r_cidx, 3'd0} -: 8];
                    n_out.on_color       = to565(r_color);
                    n_out.off_color      = to565(r_bg);
                    n_out.last_column    = (r_cidx == 3'(COLS_PER_GLYPH - 1))
                                        && (r_gnum == 2'd2 || !later_glyph);
                    if (r_cidx == 3'(COLS_PER_GLYPH - 1)) begin
                        n_cidx = 3'd0;
                        n_col  = r_col + step6;
                        n_ptr  = r_ptr + 3'd1;
                        n_gnum = r_gnum + 2'd1;
                    end else begin
                        n_cidx = r_cidx + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= 8'd1;
            r_col       <= 8'd1;
            r_color     <= COLOR_WHITE;
            r_scale_big <= 1'b1;
            r_phase     <= PH_IDLE;
            r_pend0     <= 8'd0;
            r_pend1     <= 8'd0;
            r_hex       <= 24'd0;
            r_bg        <= 24'd0;
            r_act_cnt   <= 3'd0;
            r_ptr       <= 3'd0;
            r_gnum      <= 2'd0;
            r_cidx      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_color     <= n_color;
            r_scale_big <= n_scale_big;
            r_phase     <= n_phase;
            r_pend0     <= n_pend0;
            r_pend1     <= n_pend1;
            r_hex       <= n_hex;
            if (i_cfg_we) r_bg <= i_cfg_data;
            r_act_cnt   <= n_act_cnt;
            r_ptr       <= n_ptr;
            r_gnum      <= n_gnum;
            r_cidx      <= n_cidx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acts <= n_acts;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/teg_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the glyph renderer core, bound to the top level.
// Depends on teg_pkg.
module teg_checker
    import teg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_data,
    input logic        i_cfg_we,
    input logic [23:0] i_cfg_data
);

    // a stalled transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dot_scale == 2'd1 || o_out_data.dot_scale == 2'd2))
        else $error("bad dot scale");

    a_rst_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    // while busy on a byte, nothing new is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall && o_in_stall |=> o_in_stall || !o_out_valid
            || o_out_data.last_column || $stable(o_out_data))
        else $error("input taken mid glyph");

endmodule

bind text_escape_glyph_renderer_core teg_checker u_teg_checker (.*);

[tb/text_escape_glyph_renderer_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_escape_glyph_renderer_core: a cycle-free predictor of
// cursor, color, scale and escape handling checks every column transfer.
// Depends on teg_pkg and the core RTL.
module text_escape_glyph_renderer_core_test;
    import teg_pkg::*;

    localparam int GLYPHS = 99;
    localparam int ROW_ESC_MAX = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_COLS = 15;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [23:0] i_cfg_data;

    text_escape_glyph_renderer_core #(
        .GLYPH_COUNT(GLYPHS),
        .MAX_ROW_ESCAPE(ROW_ESC_MAX)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [7:0]  m_row, m_col;
    logic [23:0] m_color, m_bg, m_hex;
    logic        m_big;
    t_phase      m_phase;
    logic [7:0]  m_pdig, m_hcnt;
    logic [7:0]  font [0:98][0:4];

    t_out_item   col_q[$];
    t_out_item   step_cols[$];
    int          errors = 0;
    int          columns_seen = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        done_flag = 1'b0;

    function automatic logic [15:0] rgb16(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [1:0] dot_sz();
        return m_big ? 2'd2 : 2'd1;
    endfunction

    task automatic draw_glyph(input int idx);
        t_out_item c;
        if (idx >= GLYPHS) idx = 31;
        for (int i = 0; i < 5; i++) begin
            c.column_x = m_col + 8'(i * dot_sz());
            c.column_y = m_row;
            c.dot_scale = dot_sz();
            c.column_bits = font[idx][i];
            c.on_color = rgb16(m_color);
            c.off_color = rgb16(m_bg);
            c.last_column = 1'b0;
            step_cols.push_back(c);
        end
        m_col = m_col + 8'(6 * dot_sz());
    endtask

    task automatic print_byte(input logic [7:0] b);
        if (b < 32 || b >= 128) b = "?";
        draw_glyph(b - 32);
    endtask

    task automatic put_row(input int d);
        int r;
        r = (1 + 9 * dot_sz() * d) & 8'hFF;
        if (r > 60 || (r >= 54 && m_big)) r = 18 * dot_sz();
        m_row = 8'(r);
    endtask

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return b - "0";
        if (b >= "A" && b <= "F") return b - "A" + 10;
        if (b >= "a" && b <= "f") return b - "a" + 10;
        return -1;
    endfunction

    task automatic plain_char(input logic [7:0] b);
        if (b == 8'h0D) return;
        if (b == 8'h0A) begin
            m_row = m_row + 8'(9 * dot_sz());
            m_col = 1;
        end else if (b == 8'h09) begin
            if (m_col < 25 && !m_big) m_col = 25;
            else if (m_col < 49) m_col = 49;
            else if (m_col < 73 && !m_big) m_col = 75;
            else begin
                m_col = 1;
                m_row = m_row + 8'(9 * dot_sz());
            end
        end else begin
            print_byte(b);
        end
    endtask

    task automatic idle_char(input logic [7:0] b);
        if (b == SLASH_CH) m_phase = PH_SLASH;
        else if (b == DOLLAR_CH) m_phase = PH_DOLLAR;
        else plain_char(b);
    endtask

    task automatic render_byte(input t_in_item it);
        logic [7:0]  b;
        logic [24:0] nc;
        int          h;
        b = it.text_byte;
        case (m_phase)
            PH_SLASH: begin
                m_phase = PH_IDLE;
                nc = named_color(b);
                if (b >= "0" && b <= 8'("0" + ROW_ESC_MAX)) begin
                    put_row(b - "0");
                    m_col = 1;
                end else if (b == "#") begin
                    m_phase = PH_HEX;
                    m_hcnt = 0;
                    m_hex = 0;
                end else if (b == "S") m_big = 1'b1;
                else if (b == "s") m_big = 1'b0;
                else if (nc[24]) m_color = nc[23:0];
                else if (b == "/") print_byte("/");
                else if (b == "*") draw_glyph(98);
                else if (b == "q") draw_glyph(97);
                else if (b == "Q") draw_glyph(96);
                else begin
                    print_byte("/");
                    idle_char(b);
                end
            end
            PH_DOLLAR: begin
                if (b >= "0" && b <= 8'("0" + ROW_ESC_MAX)) begin
                    m_pdig = b;
                    m_phase = PH_DOLLAR_DIGIT;
                end else begin
                    m_phase = PH_IDLE;
                    print_byte("$");
                    idle_char(b);
                end
            end
            PH_DOLLAR_DIGIT: begin
                m_phase = PH_IDLE;
                if ((b >= "0" && b <= "9") || (b >= "A" && b <= "F")) begin
                    put_row(m_pdig - "0");
                    h = (b >= "A") ? b - "A" + 10 : b - "0";
                    m_col = 8'(1 + 6 * dot_sz() * h);
                end else begin
                    print_byte("$");
                    print_byte(m_pdig);
                    idle_char(b);
                end
            end
            PH_HEX: begin
                h = hex_digit(b);
                if (h >= 0) m_hex = {m_hex[19:0], 4'(h)};
                m_hcnt = m_hcnt + 1;
                if (m_hcnt >= 6) begin
                    m_color = m_hex;
                    m_phase = PH_IDLE;
                end
            end
            default: begin
                m_phase = PH_IDLE;
                idle_char(b);
            end
        endcase
        if (it.end_of_text) begin
            case (m_phase)
                PH_SLASH: print_byte("/");
                PH_DOLLAR: print_byte("$");
                PH_DOLLAR_DIGIT: begin
                    print_byte("$");
                    print_byte(m_pdig);
                end
                PH_HEX: m_color = m_hex;
                default: ;
            endcase
            m_phase = PH_IDLE;
        end
        // a byte yields at most fifteen columns; extra glyphs only move the cursor
        if (step_cols.size() > MAX_COLS) step_cols = step_cols[0:MAX_COLS - 1];
        if (step_cols.size() > 0) step_cols[step_cols.size() - 1].last_column = 1'b1;
        while (step_cols.size() > 0) col_q.push_back(step_cols.pop_front());
    endtask

    // sender: drives one byte, holds it until the transfer; the caller either
    // sends the next byte or drops valid at the returning falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{text_byte: b, end_of_text: eot};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        render_byte('{text_byte: b, end_of_text: eot});
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
    endtask

    task automatic drain_and_config(input logic [23:0] bg);
        i_in_valid <= 1'b0;
        while (col_q.size() > 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= bg;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        m_bg = bg;
    endtask

    // output monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            columns_seen++;
            if (col_q.size() == 0) begin
                $error("unexpected column transfer %h", o_out_data);
                errors++;
            end else begin
                want = col_q.pop_front();
                if (o_out_data.column_x !== want.column_x) begin
                    $error("column_x exp %0d got %0d", want.column_x, o_out_data.column_x);
                    errors++;
                end
                if (o_out_data.column_y !== want.column_y) begin
                    $error("column_y exp %0d got %0d", want.column_y, o_out_data.column_y);
                    errors++;
                end
                if (o_out_data.dot_scale !== want.dot_scale) begin
                    $error("dot_scale exp %0d got %0d", want.dot_scale, o_out_data.dot_scale);
                    errors++;
                end
                if (o_out_data.column_bits !== want.column_bits) begin
                    $error("column_bits exp %h got %h", want.column_bits,
                           o_out_data.column_bits);
                    errors++;
                end
                if (o_out_data.on_color !== want.on_color) begin
                    $error("on_color exp %h got %h", want.on_color, o_out_data.on_color);
                    errors++;
                end
                if (o_out_data.off_color !== want.off_color) begin
                    $error("off_color exp %h got %h", want.off_color, o_out_data.off_color);
                    errors++;
                end
                if (o_out_data.last_column !== want.last_column) begin
                    $error("last_column exp %b got %b", want.last_column,
                           o_out_data.last_column);
                    errors++;
                end
            end
        end
    end

    // receiver stall and watchdog
    always @(negedge i_clk) begin
        i_out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we
            || done_flag)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // directed rows: bytes, end flag, and for the first row the expected first column
    typedef struct {
        string      txt;
        logic       eot;
        logic       has_exp;
        t_out_item  exp_first;
    } t_row;

    t_row rows[$];
    t_out_item fixed_col;

    task automatic add_row(input string s, input logic eot);
        rows.push_back('{txt: s, eot: eot, has_exp: 1'b0, exp_first: '0});
    endtask

    string named = "rgbycmwkRGBolitepMAa";
    string hexch = "0123456789abcdefABCDEF#gz";
    string hexup = "0123456789ABCDEF";
    string ctl   = "\t\n\r*qQ/$";

    initial begin
        t_row        r;
        logic [7:0]  b;
        int          kind, n;
        logic [23:0] bgs [4];

        {font[0][0], font[0][1], font[0][2], font[0][3], font[0][4]} = 40'h0;
        for (int g = 0; g < 99; g++)
            {font[g][0], font[g][1], font[g][2], font[g][3], font[g][4]} = glyph_cols(7'(g));

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        m_row = 1; m_col = 1; m_color = COLOR_WHITE; m_bg = 0; m_hex = 0;
        m_big = 1'b1; m_phase = PH_IDLE; m_pdig = 0; m_hcnt = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first glyph after reset: space at (1,1), scale 2, white on black
        fixed_col = '{column_x: 8'd1, column_y: 8'd1, dot_scale: 2'd2, column_bits: 8'h00,
                      on_color: 16'hFFFF, off_color: 16'h0000, last_column: 1'b0};
        rows.push_back('{txt: " ", eot: 1'b0, has_exp: 1'b1, exp_first: fixed_col});
        add_row("~\x7f", 1'b0);
        add_row("//", 1'b0);
        add_row("/0/6", 1'b0);
        add_row("$6F", 1'b0);
        add_row("/s$0A/1x", 1'b0);
        add_row("\t\t\t\t\n\r/S\t\t", 1'b0);
        add_row("/*/q/Q", 1'b0);
        add_row("/#12ab3Zc", 1'b0);
        add_row("/z$9$3Z", 1'b0);
        add_row("/#fF", 1'b1);
        add_row("$5", 1'b1);
        add_row("$", 1'b1);
        add_row("/", 1'b1);
        add_row("/R/a", 1'b0);

        foreach (rows[k]) begin
            r = rows[k];
            if (r.has_exp) begin
                // only the first column's fields can be read off directly
                send_text(r.txt, r.eot);
                if (col_q.size() > 0 && col_q[0] != r.exp_first) begin
                    $error("first column exp %h got %h", r.exp_first, col_q[0]);
                    errors++;
                end
            end else begin
                send_text(r.txt, r.eot);
            end
        end
        // control bytes and high bytes, all bits toggling
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);

        bgs[0] = 24'hFFFFFF; bgs[1] = 24'h123456; bgs[2] = 24'hA5A5A5; bgs[3] = 24'h000000;
        for (int ph = 0; ph < 4; ph++) begin
            drain_and_config(bgs[ph]);
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 27 : 58) : 0;
            stall_pct = (ph == 2) ? 58 : (ph == 3 ? 27 : 0);
            for (int k = 0; k < 30; k++) begin
                kind = $urandom_range(9);
                case (kind)
                    0: begin
                        send_byte("/", 1'b0);
                        send_byte(named[$urandom_range(named.len() - 1)], 1'b0);
                    end
                    1: begin
                        send_byte("/", 1'b0);
                        send_byte("#", 1'b0);
                        n = $urandom_range(6, 1);
                        for (int j = 0; j < n; j++)
                            send_byte(hexch[$urandom_range(hexch.len() - 1)],
                                      j == n - 1 && $urandom_range(1));
                    end
                    2: begin
                        send_byte("$", 1'b0);
                        send_byte(8'("0" + $urandom_range(6)), 1'b0);
                        send_byte(hexup[$urandom_range(15)], 1'b0);
                    end
                    3: begin
                        send_byte("/", 1'b0);
                        send_byte(8'("0" + $urandom_range(6)), 1'b0);
                    end
                    4: begin
                        send_byte("/", 1'b0);
                        send_byte($urandom_range(1) ? "S" : "s", 1'b0);
                    end
                    5: begin
                        b = ctl[$urandom_range(7)];
                        send_byte($urandom_range(1) ? "/" : b, 1'b0);
                        send_byte(b, $urandom_range(3) == 0);
                    end
                    6: send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
                    default: send_byte(8'($urandom_range(126, 32)), $urandom_range(15) == 0);
                endcase
            end
            send_byte(" ", 1'b1);
        end

        i_in_valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (col_q.size() > 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        done_flag = 1'b1;
        $display("Rendered %0d bytes into %0d checked columns", bytes_sent, columns_seen);
        $display("over four background colors and four idle/stall mixes");
        if (errors == 0 && col_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
